### src/drpi_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the dead-reckoning pose integrator.
// Used by drpi_ctrl, drpi_datapath and the top level; depends on nothing.
package drpi_pkg;

  // CORDIC start value: inverse gain in Q30
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ITER,
    ST_FINISH,
    ST_MUL,
    ST_ACC,
    ST_OUT
  } state_t;

  // Command word from the controller to the datapath
  typedef struct packed {
    logic       capture;
    logic       load;
    logic       iter;
    logic       finish;
    logic       mul;
    logic       acc;
    logic       out_load;
    logic       lane;
    logic [4:0] idx;
  } cmd_t;

  // atan(2^-i) as a 32-bit binary angle per full turn
  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

### src/dead_reckoning_pose_integrator_unit.sv
`timescale 1ns / 1ps
// Planar dead-reckoning pose integrator. Each input beat updates heading or
// speed and carries a timestamp; one result beat follows with position,
// heading, velocity components and the yaw quaternion. An item passes in
// order through capture, CORDIC load together with forming speed*dt,
// CORDIC_STEPS iterations of a two-lane rotation unit (heading and half
// heading together), fold and clamp, two multiply/accumulate passes for the
// x and y axes, and the load of the output register. The input stalls while
// an item is in work; a finished result waits in the output register while
// the next item runs. Depends on drpi_pkg, drpi_ctrl and drpi_datapath.
module dead_reckoning_pose_integrator_unit import drpi_pkg::*; #(
  parameter int ANGLE_BITS   = 16,
  parameter int POS_BITS     = 48,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                operation,
  input  logic signed [15:0]  value,
  input  logic [31:0]         timestamp,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [47:0]  pos_x,
  output logic signed [47:0]  pos_y,
  output logic signed [15:0]  heading,
  output logic signed [15:0]  vel_x,
  output logic signed [15:0]  vel_y,
  output logic signed [15:0]  quat_z,
  output logic signed [15:0]  quat_w
);

  cmd_t cmd;

  drpi_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  drpi_datapath #(
    .ANGLE_BITS(ANGLE_BITS),
    .POS_BITS  (POS_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .operation (operation),
    .value     (value),
    .timestamp (timestamp),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .heading   (heading),
    .vel_x     (vel_x),
    .vel_y     (vel_y),
    .quat_z    (quat_z),
    .quat_w    (quat_w)
  );

endmodule

### src/drpi_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the pose integrator: input and output handshakes,
// CORDIC step counter and lane select. Depends on drpi_pkg.
module drpi_ctrl import drpi_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output cmd_t cmd
);

  localparam int IW = $clog2(CORDIC_STEPS);
  localparam logic [IW-1:0] LAST_IDX = IW'(CORDIC_STEPS - 1);

  state_t          state, state_next;
  logic [IW-1:0]   idx, idx_next;
  logic            lane, lane_next;
  logic            out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      lane      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      idx       <= idx_next;
      lane      <= lane_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    idx_next   = idx;
    lane_next  = lane;
    cmd        = '0;
    cmd.lane   = lane;
    cmd.idx    = 5'(idx);
    out_valid_next = out_valid & out_stall;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load   = 1'b1;
        idx_next   = '0;
        state_next = ST_ITER;
      end
      ST_ITER: begin
        cmd.iter = 1'b1;
        if (idx == LAST_IDX) begin
          state_next = ST_FINISH;
        end else begin
          idx_next = idx + IW'(1);
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        lane_next  = 1'b0;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc = 1'b1;
        if (lane) begin
          state_next = ST_OUT;
        end else begin
          lane_next  = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_OUT: begin
        // hold until the output slot is free or its beat is taken now
        if (!out_valid || !out_stall) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### src/drpi_datapath.sv
`timescale 1ns / 1ps
// Datapath: pose state, two-lane iterative CORDIC (heading and half heading),
// step multipliers, saturating accumulate and output register. Uses drpi_pkg.
module drpi_datapath import drpi_pkg::*; #(
  parameter int ANGLE_BITS = 16,
  parameter int POS_BITS   = 48
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  input  logic                operation,
  input  logic signed [15:0]  value,
  input  logic [31:0]         timestamp,
  output logic signed [47:0]  pos_x,
  output logic signed [47:0]  pos_y,
  output logic signed [15:0]  heading,
  output logic signed [15:0]  vel_x,
  output logic signed [15:0]  vel_y,
  output logic signed [15:0]  quat_z,
  output logic signed [15:0]  quat_w
);

  localparam logic [31:0] PHASE_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
  localparam int DW = 44;
  localparam int SW = ((POS_BITS > DW) ? POS_BITS : DW) + 1;
  localparam logic signed [SW-1:0] PMAX =
    {{(SW - POS_BITS + 1){1'b0}}, {(POS_BITS - 1){1'b1}}};
  localparam logic signed [SW-1:0] PMIN = ~PMAX;
  localparam logic signed [66:0] RND23 = 67'sd1 <<< 22;
  localparam logic signed [48:0] RND30 = 49'sd1 <<< 29;
  localparam logic signed [33:0] ONE_Q30 = 34'sd1 <<< 30;

  // pose state
  logic signed [POS_BITS-1:0] position_x, position_y;
  logic signed [15:0]         stored_heading, stored_speed;
  logic [31:0]                last_stamp, dt;
  logic                       stamp_seen;

  // CORDIC lanes: 0 = heading, 1 = half heading
  logic signed [33:0] cx [2];
  logic signed [33:0] cy [2];
  logic signed [33:0] cz [2];
  logic               flip [2];
  logic signed [31:0] cres [2];
  logic signed [31:0] sres [2];

  logic signed [48:0] vd;
  logic signed [65:0] p_hi;
  logic signed [64:0] p_lo;
  logic signed [47:0] p_vel;
  logic signed [15:0] vel_x_r, vel_y_r, quat_z_r, quat_w_r;

  function automatic logic signed [31:0] clamp_q30(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > ONE_Q30) r = 32'(ONE_Q30);
    else if (v < -ONE_Q30) r = 32'(-ONE_Q30);
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [15:0] quat_of(input logic signed [31:0] s);
    logic signed [32:0] t;
    logic signed [16:0] q;
    logic signed [15:0] r;
    t = 33'(s) + 33'sd32768;
    q = t[32:16];
    if (q > 17'sd16384) r = 16'sd16384;
    else if (q < -17'sd16384) r = -16'sd16384;
    else r = q[15:0];
    return r;
  endfunction

  // lane phases and fold
  logic [31:0]        ph [2];
  logic               fl [2];
  logic signed [33:0] z0 [2];
  logic signed [33:0] nx [2];
  logic signed [33:0] ny [2];
  logic signed [33:0] nz [2];
  logic signed [33:0] at;

  always_comb begin
    ph[0] = {stored_heading, 16'h0000} & PHASE_MASK;
    ph[1] = {ph[0][31], ph[0][31:1]};
    at    = 34'(atan_entry(cmd.idx));
    for (int l = 0; l < 2; l++) begin
      fl[l] = ph[l][31] ^ ph[l][30];
      z0[l] = 34'($signed({ph[l][31] ^ fl[l], ph[l][30:0]}));
      if (!cz[l][33]) begin
        nx[l] = cx[l] - (cy[l] >>> cmd.idx);
        ny[l] = cy[l] + (cx[l] >>> cmd.idx);
        nz[l] = cz[l] - at;
      end else begin
        nx[l] = cx[l] + (cy[l] >>> cmd.idx);
        ny[l] = cy[l] - (cx[l] >>> cmd.idx);
        nz[l] = cz[l] + at;
      end
    end
  end

  // step and velocity terms for the selected axis
  logic signed [31:0]  trig;
  logic signed [16:0]  ch;
  logic signed [15:0]  cl;
  logic signed [66:0]  acc_sum;
  logic signed [DW-1:0] delta;
  logic signed [SW-1:0] pos_sum;
  logic signed [POS_BITS-1:0] pos_sel, pos_new;
  logic signed [48:0]  vsum;
  logic signed [18:0]  vq;
  logic signed [15:0]  vel_new;

  always_comb begin
    trig    = cmd.lane ? sres[0] : cres[0];
    ch      = trig[31:15];
    cl      = $signed({1'b0, trig[14:0]});
    acc_sum = 67'(p_hi) + 67'(p_lo >>> 15) + RND23;
    delta   = acc_sum[66:23];
    pos_sel = cmd.lane ? position_y : position_x;
    pos_sum = SW'(pos_sel) + SW'(delta);
    if (pos_sum > PMAX) pos_new = PMAX[POS_BITS-1:0];
    else if (pos_sum < PMIN) pos_new = PMIN[POS_BITS-1:0];
    else pos_new = pos_sum[POS_BITS-1:0];
    vsum = 49'(p_vel) + RND30;
    vq   = vsum[48:30];
    if (vq > 19'sd32767) vel_new = 16'sd32767;
    else if (vq < -19'sd32768) vel_new = -16'sd32768;
    else vel_new = vq[15:0];
  end

  // pose state
  always_ff @(posedge clk) begin
    if (rst) begin
      position_x     <= '0;
      position_y     <= '0;
      stored_heading <= '0;
      stored_speed   <= '0;
      last_stamp     <= '0;
      stamp_seen     <= 1'b0;
    end else begin
      if (cmd.capture) begin
        if (operation) stored_speed <= value;
        else stored_heading <= value;
        last_stamp <= timestamp;
        stamp_seen <= 1'b1;
      end
      if (cmd.acc) begin
        if (cmd.lane) position_y <= pos_new;
        else position_x <= pos_new;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      dt <= stamp_seen ? (timestamp - last_stamp) : 32'd0;
    end
    if (cmd.load) begin
      vd <= 49'(stored_speed) * 49'($signed({1'b0, dt}));
      for (int l = 0; l < 2; l++) begin
        cx[l]   <= CORDIC_GAIN_Q30;
        cy[l]   <= '0;
        cz[l]   <= z0[l];
        flip[l] <= fl[l];
      end
    end
    if (cmd.iter) begin
      for (int l = 0; l < 2; l++) begin
        cx[l] <= nx[l];
        cy[l] <= ny[l];
        cz[l] <= nz[l];
      end
    end
    if (cmd.finish) begin
      for (int l = 0; l < 2; l++) begin
        cres[l] <= clamp_q30(flip[l] ? -cx[l] : cx[l]);
        sres[l] <= clamp_q30(flip[l] ? -cy[l] : cy[l]);
      end
    end
    if (cmd.mul) begin
      p_hi  <= 66'(vd) * 66'(ch);
      p_lo  <= 65'(vd) * 65'(cl);
      p_vel <= 48'(stored_speed) * 48'(trig);
      if (!cmd.lane) begin
        quat_z_r <= quat_of(sres[1]);
        quat_w_r <= quat_of(cres[1]);
      end
    end
    if (cmd.acc) begin
      if (cmd.lane) vel_y_r <= vel_new;
      else vel_x_r <= vel_new;
    end
  end

  // output beat register
  logic signed [63:0] ext_x, ext_y;
  assign ext_x = 64'(position_x);
  assign ext_y = 64'(position_y);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      pos_x   <= ext_x[47:0];
      pos_y   <= ext_y[47:0];
      heading <= stored_heading;
      vel_x   <= vel_x_r;
      vel_y   <= vel_y_r;
      quat_z  <= quat_z_r;
      quat_w  <= quat_w_r;
    end
  end

endmodule

### tb/dead_reckoning_pose_integrator_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for dead_reckoning_pose_integrator_unit: heading and speed beats in,
// pose beats out, each checked against a bit-exact CORDIC and integrator predictor.
// Stands alone; needs only the RTL of the block.

typedef enum bit {
  OP_HEADING = 1'b0,
  OP_SPEED   = 1'b1
} update_op_e;

typedef struct packed {
  logic signed [47:0] px;
  logic signed [47:0] py;
  logic signed [15:0] hdg;
  logic signed [15:0] vx;
  logic signed [15:0] vy;
  logic signed [15:0] qz;
  logic signed [15:0] qw;
} pose_t;

class pose_scoreboard;
  localparam int STEPS = 16;
  localparam longint GAIN = 64'sd652032874;
  localparam longint UNIT = 64'sd1073741824;
  localparam longint RAIL_HI = 64'sd140737488355327;
  localparam longint RAIL_LO = -64'sd140737488355328;

  bit [31:0] atan_lut [STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  longint acc_x = 0;
  longint acc_y = 0;
  shortint hdg_q = 0;
  shortint spd_q = 0;
  bit [31:0] prev_stamp = '0;
  bit stamp_valid = 1'b0;
  pose_t expected_q[$];
  int errors = 0;
  int checked = 0;
  int headings = 0;
  int speeds = 0;
  int rail_x = 0;
  int rail_y = 0;

  function longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Rotation-mode CORDIC over a 32-bit binary angle; results in Q30
  function void rotate(input bit [31:0] ang, output longint c, output longint s);
    longint x, y, z, dx, dy;
    bit flip;
    x = GAIN;
    y = 0;
    // fold the left half-plane by pi and negate at the end
    flip = ang[31] ^ ang[30];
    if (flip) ang = ang + 32'h8000_0000;
    z = longint'($signed(ang));
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= longint'(atan_lut[i]);
      end else begin
        x += dx;
        y -= dy;
        z += longint'(atan_lut[i]);
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = clip(x, -UNIT, UNIT);
    s = clip(y, -UNIT, UNIT);
  endfunction

  // Split the Q30 factor so the product stays inside 64 bits
  function longint advance(longint vd, longint cs);
    longint hi, lo;
    hi = cs >>> 15;
    lo = cs - hi * 32768;
    return (vd * hi + ((vd * lo) >>> 15) + 64'sd4194304) >>> 23;
  endfunction

  function void note_update(update_op_e op, logic signed [15:0] val, logic [31:0] stamp);
    bit [31:0] dt, ang, half;
    longint c, s, hc, hs, vd;
    pose_t e;
    if (op == OP_SPEED) begin
      spd_q = val;
      speeds++;
    end else begin
      hdg_q = val;
      headings++;
    end
    dt = stamp_valid ? stamp - prev_stamp : 32'd0;
    prev_stamp = stamp;
    stamp_valid = 1'b1;

    ang = {hdg_q, 16'h0000};
    half = $signed(ang) >>> 1;
    rotate(ang, c, s);
    rotate(half, hc, hs);

    vd = longint'(spd_q) * longint'(dt);
    acc_x = clip(acc_x + advance(vd, c), RAIL_LO, RAIL_HI);
    acc_y = clip(acc_y + advance(vd, s), RAIL_LO, RAIL_HI);
    if (acc_x == RAIL_LO || acc_x == RAIL_HI) rail_x++;
    if (acc_y == RAIL_LO || acc_y == RAIL_HI) rail_y++;

    e.px = acc_x[47:0];
    e.py = acc_y[47:0];
    e.hdg = hdg_q;
    e.vx = 16'(clip((longint'(spd_q) * c + 64'sd536870912) >>> 30, -32768, 32767));
    e.vy = 16'(clip((longint'(spd_q) * s + 64'sd536870912) >>> 30, -32768, 32767));
    e.qz = 16'(clip((hs + 32768) >>> 16, -16384, 16384));
    e.qw = 16'(clip((hc + 32768) >>> 16, -16384, 16384));
    expected_q.push_back(e);
  endfunction

  function void cmp(string field, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      errors++;
    end
  endfunction

  function void check_result(pose_t got);
    pose_t want;
    if (expected_q.size() == 0) begin
      $error("pose beat arrived with no update waiting");
      errors++;
    end else begin
      want = expected_q.pop_front();
      checked++;
      cmp("pos_x", want.px, got.px);
      cmp("pos_y", want.py, got.py);
      cmp("heading", want.hdg, got.hdg);
      cmp("vel_x", want.vx, got.vx);
      cmp("vel_y", want.vy, got.vy);
      cmp("quat_z", want.qz, got.qz);
      cmp("quat_w", want.qw, got.qw);
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module dead_reckoning_pose_integrator_unit_tb;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic operation = 1'b0;
  logic signed [15:0] value = '0;
  logic [31:0] timestamp = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [47:0] pos_x;
  logic signed [47:0] pos_y;
  logic signed [15:0] heading;
  logic signed [15:0] vel_x;
  logic signed [15:0] vel_y;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;

  pose_scoreboard sb = new;
  bit [31:0] stamp = 32'h1234_5678;
  bit calm = 1'b0;
  bit gaps_on = 1'b1;
  int quiet_cycles = 0;

  dead_reckoning_pose_integrator_unit u_top (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin : monitor
    pose_t seen;
    bit in_beat, out_beat;
    seen = '{pos_x, pos_y, heading, vel_x, vel_y, quat_z, quat_w};
    out_beat = !rst && out_valid && !out_stall;
    in_beat = !rst && in_valid && !in_stall;
    if (out_beat) sb.check_result(seen);
    if (in_beat) sb.note_update(update_op_e'(operation), value, timestamp);
    if (in_beat || out_beat) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("timeout: no beat moved for %0d cycles", QUIET_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // Result side: stall bursts between open windows, none once calm
  initial begin : sink
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(30, 90) : $urandom_range(1, 12))
        @(posedge clk);
    end
  end

  // Hold the beat until it is taken; valid stays high for a back-to-back beat
  task automatic send_update(update_op_e op, logic signed [15:0] val, bit [31:0] at);
    if (gaps_on && !calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    stamp = at;
    in_valid <= 1'b1;
    operation <= op;
    value <= val;
    timestamp <= at;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'(int'($urandom_range(0, 128)) - 64);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic bit [31:0] pick_stamp();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return stamp;
      default: return stamp + $urandom_range(1, 262144);
    endcase
  endfunction

  // Near-full speed with near-maximal elapsed time drives one axis into its rail
  task automatic push_to_rail(logic signed [15:0] course, int count);
    send_update(OP_SPEED, 16'sh7FFF, stamp + 32'd65536);
    repeat (count) begin
      if ($urandom_range(0, 3) == 0)
        send_update(OP_HEADING, 16'(course + $urandom_range(0, 400) - 200),
                    stamp + $urandom_range(32'hF000_0000, 32'hFFFF_FFFF));
      else
        send_update(OP_SPEED, 16'($urandom_range(30000, 32767)),
                    stamp + $urandom_range(32'hF000_0000, 32'hFFFF_FFFF));
    end
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // first beat after reset carries no elapsed time
    send_update(OP_SPEED, 16'sh7FFF, stamp);
    send_update(OP_HEADING, 16'sh0000, stamp + 32'd65536);
    send_update(OP_HEADING, 16'sd16384, stamp + 32'd65536);
    send_update(OP_HEADING, 16'sh8000, stamp + 32'd65536);
    send_update(OP_HEADING, 16'sh7FFF, stamp + 32'd1);
    send_update(OP_HEADING, -16'sd16384, stamp + 32'd65536);
    // full negative speed along an axis overflows the velocity
    send_update(OP_SPEED, 16'sh8000, stamp + 32'd65536);
    send_update(OP_HEADING, 16'sh8000, stamp + 32'd65536);
    send_update(OP_HEADING, 16'sd8192, stamp + 32'd65536);
    send_update(OP_SPEED, 16'sd0, stamp + 32'd1000);
    send_update(OP_SPEED, 16'sd1, stamp + 32'd65536);
    send_update(OP_SPEED, -16'sd1, stamp + 32'd65536);
    send_update(OP_HEADING, -16'sd1, stamp);
    send_update(OP_HEADING, 16'sd1, stamp + 32'd1);
    // time going backwards yields the wrapped difference
    send_update(OP_SPEED, 16'sh7FFF, stamp - 32'd1);
    send_update(OP_HEADING, 16'sd24576, stamp - 32'd5000);
    send_update(OP_HEADING, -16'sd24576, 32'hFFFF_FF00);
    send_update(OP_SPEED, 16'sd256, 32'h0000_0100);
    send_update(OP_HEADING, 16'sd16383, 32'hFFFF_FFFF);
    send_update(OP_HEADING, -16'sd8192, 32'h0000_0000);
    send_update(OP_SPEED, 16'sh5A5A, 32'hA5A5_A5A5);
    send_update(OP_HEADING, 16'shA5A5, 32'h5A5A_5A5A);
    wait_for_results();

    for (int n = 0; n < 350; n++) begin
      if (n % 50 == 0) gaps_on = ($urandom_range(0, 2) != 0);
      if (n == 175) wait_for_results();
      send_update(update_op_e'($urandom_range(0, 1)), pick_value(), pick_stamp());
    end

    gaps_on = 1'b1;
    push_to_rail(16'sh0000, 340);
    push_to_rail(-16'sd16384, 340);

    calm = 1'b1;
    for (int n = 0; n < 150; n++)
      send_update(update_op_e'($urandom_range(0, 1)), pick_value(), pick_stamp());

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d pose beats never arrived", sb.pending());
      sb.errors++;
    end

    $display("Checked %0d pose beats from %0d heading and %0d speed updates, %0d mismatches.",
             sb.checked, sb.headings, sb.speeds, sb.errors);
    $display("Position sat on its rail in %0d results for x and %0d for y.",
             sb.rail_x, sb.rail_y);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

### files.f
src/drpi_pkg.sv
src/drpi_ctrl.sv
src/drpi_datapath.sv
src/dead_reckoning_pose_integrator_unit.sv
tb/dead_reckoning_pose_integrator_unit_tb.sv
